// ===== rtl/casm_pkg.sv =====
// Package for the clock and alarm set menu: menu state codes, button codes,
// indicator and alarm-write codes, and the result record.
// No dependencies.
package casm_pkg;

	// Field widths
	localparam int unsigned HourW   = 5;
	localparam int unsigned MinuteW = 6;

	// Hour value that means alarm disabled / clock-set cancel
	localparam logic [HourW-1:0]   HOUR_OFF   = 5'd24;
	localparam logic [HourW-1:0]   HOUR_TOP   = 5'd23;
	localparam logic [MinuteW-1:0] MINUTE_TOP = 6'd59;

	// Menu states
	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_ALARM_H = 3'd1,
		MODE_ALARM_M = 3'd2,
		MODE_CLOCK_H = 3'd3,
		MODE_CLOCK_M = 3'd4
	} mode_t;

	// Button codes
	localparam logic [1:0] OP_INC  = 2'd0; // increment / select alarm 2
	localparam logic [1:0] OP_ADV  = 2'd1; // advance / select clock
	localparam logic [1:0] OP_DEC  = 2'd2; // decrement / select alarm 1
	localparam logic [1:0] OP_NONE = 2'd3; // no action

	// Target indicator codes
	localparam logic [1:0] TGT_NONE   = 2'd0;
	localparam logic [1:0] TGT_ALARM1 = 2'd1;
	localparam logic [1:0] TGT_ALARM2 = 2'd2;
	localparam logic [1:0] TGT_CLOCK  = 2'd3;

	// Alarm write report codes
	localparam logic [1:0] WR_NONE   = 2'd0;
	localparam logic [1:0] WR_ALARM1 = 2'd1;
	localparam logic [1:0] WR_ALARM2 = 2'd2;

	// One result item
	typedef struct packed {
		logic [2:0]         menu_state;
		logic [HourW-1:0]   shown_hour;
		logic [MinuteW-1:0] shown_minute;
		logic               show_disabled;
		logic [1:0]         target_indicator;
		logic               set_clock;
		logic [1:0]         alarm_written;
		logic               written_enabled;
	} result_t;

endpackage

// ===== rtl/casm_menu_core.sv =====
// Menu state machine: working hour/minute, target and both alarm registers.
// Computes the result of each accepted request from the updated state.
// Depends on casm_pkg.
module casm_menu_core
	import casm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  logic [1:0]         operation,
	input  logic               alarms_silent,
	input  logic [HourW-1:0]   clock_hour,
	input  logic [MinuteW-1:0] clock_minute,
	output result_t            result
);

	mode_t              mode_q, mode_d;
	logic [HourW-1:0]   hour_q, hour_d;
	logic [MinuteW-1:0] minute_q, minute_d;
	logic               dis_q, dis_d;
	logic               second_q, second_d;
	logic [HourW-1:0]   al_hour_q [2];
	logic [MinuteW-1:0] al_min_q  [2];
	logic [1:0]         al_en_q, al_en_d;
	logic               al_store;
	logic               set_clk;
	logic [1:0]         written;
	logic               wen;
	logic [HourW-1:0]   hour_inc, hour_dec, hour_dm1;
	logic [MinuteW-1:0] min_inc, min_dec;

	// Hour and minute stepping
	always_comb begin
		hour_inc = (hour_q >= HOUR_OFF) ? '0 : hour_q + 1'b1;
		hour_dm1 = hour_q - 1'b1;
		if (hour_q == '0) begin
			hour_dec = HOUR_OFF;
		end else if (hour_dm1 > HOUR_OFF) begin
			hour_dec = '0;
		end else begin
			hour_dec = hour_dm1;
		end
		min_inc = (minute_q >= MINUTE_TOP) ? '0 : minute_q + 1'b1;
		min_dec = (minute_q == '0 || minute_q > MINUTE_TOP) ? MINUTE_TOP : minute_q - 1'b1;
	end

	// Next state
	always_comb begin
		mode_d   = mode_q;
		hour_d   = hour_q;
		minute_d = minute_q;
		dis_d    = dis_q;
		second_d = second_q;
		al_en_d  = al_en_q;
		al_store = 1'b0;
		set_clk  = 1'b0;
		written  = WR_NONE;
		wen      = 1'b0;
		if (take && alarms_silent && operation != OP_NONE) begin
			case (mode_q)
				MODE_ALARM_H, MODE_CLOCK_H: begin
					if (operation == OP_INC) begin
						hour_d = hour_inc;
						dis_d  = (hour_inc == HOUR_OFF);
					end else if (operation == OP_DEC) begin
						hour_d = hour_dec;
						dis_d  = (hour_dec == HOUR_OFF);
					end else if (dis_q) begin
						if (mode_q == MODE_ALARM_H) begin
							al_en_d[second_q] = 1'b0;
							written = second_q ? WR_ALARM2 : WR_ALARM1;
						end
						mode_d = MODE_IDLE;
					end else begin
						mode_d = (mode_q == MODE_ALARM_H) ? MODE_ALARM_M : MODE_CLOCK_M;
					end
				end
				MODE_ALARM_M, MODE_CLOCK_M: begin
					if (operation == OP_INC) begin
						minute_d = min_inc;
					end else if (operation == OP_DEC) begin
						minute_d = min_dec;
					end else begin
						if (mode_q == MODE_ALARM_M) begin
							al_store          = 1'b1;
							al_en_d[second_q] = 1'b1;
							written           = second_q ? WR_ALARM2 : WR_ALARM1;
							wen               = 1'b1;
						end else begin
							set_clk = 1'b1;
						end
						mode_d = MODE_IDLE;
					end
				end
				default: begin
					if (operation == OP_ADV) begin
						hour_d   = (clock_hour > HOUR_TOP) ? '0 : clock_hour;
						minute_d = (clock_minute > MINUTE_TOP) ? '0 : clock_minute;
						dis_d    = 1'b0;
						mode_d   = MODE_CLOCK_H;
					end else begin
						// increment picks alarm 2, decrement alarm 1
						second_d = (operation == OP_INC);
						hour_d   = al_hour_q[second_d];
						minute_d = al_min_q[second_d];
						dis_d    = ~al_en_q[second_d];
						mode_d   = MODE_ALARM_H;
					end
				end
			endcase
		end
	end

	// Result from the updated state
	always_comb begin
		result.menu_state    = mode_d;
		result.shown_hour    = dis_d ? '0 : hour_d;
		result.shown_minute  = dis_d ? '0 : minute_d;
		result.show_disabled = dis_d;
		case (mode_d)
			MODE_ALARM_H, MODE_ALARM_M: result.target_indicator = second_d ? TGT_ALARM2 : TGT_ALARM1;
			MODE_CLOCK_H, MODE_CLOCK_M: result.target_indicator = TGT_CLOCK;
			default:                    result.target_indicator = TGT_NONE;
		endcase
		result.set_clock       = set_clk;
		result.alarm_written   = written;
		result.written_enabled = wen;
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_IDLE;
			hour_q       <= '0;
			minute_q     <= '0;
			dis_q        <= 1'b0;
			second_q     <= 1'b0;
			al_en_q      <= '0;
			al_hour_q[0] <= '0;
			al_hour_q[1] <= '0;
			al_min_q[0]  <= '0;
			al_min_q[1]  <= '0;
		end else begin
			mode_q   <= mode_d;
			hour_q   <= hour_d;
			minute_q <= minute_d;
			dis_q    <= dis_d;
			second_q <= second_d;
			al_en_q  <= al_en_d;
			if (al_store) begin
				al_hour_q[second_q] <= hour_q;
				al_min_q[second_q]  <= minute_q;
			end
		end
	end

endmodule

// ===== rtl/casm_out_buf.sv =====
// Two-entry output buffer (result register plus skid register) for the
// result channel; the input stall comes from a register only.
// Depends on casm_pkg.
module casm_out_buf
	import casm_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    full,
	output logic    out_valid,
	input  logic    out_stall,
	output result_t out_data
);

	logic    main_vld_q;
	logic    skid_vld_q;
	result_t main_q;
	result_t skid_q;
	logic    main_free;

	assign main_free = !main_vld_q || !out_stall;
	assign full      = skid_vld_q;
	assign out_valid = main_vld_q;
	assign out_data  = main_q;

	// Valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (main_free) begin
			main_vld_q <= skid_vld_q || push;
			skid_vld_q <= 1'b0;
		end else if (push) begin
			skid_vld_q <= 1'b1;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (main_free) begin
			main_q <= skid_vld_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule

// ===== rtl/clock_alarm_set_menu_fsm_top.sv =====
// Clock and alarm set menu, top level.
// Holds the menu state machine and the result buffer.
// Depends on casm_pkg, casm_menu_core, casm_out_buf.
//
// Usage:
// - Request channel: in_valid / in_stall carry one button event (operation,
//   alarms_silent, clock_hour, clock_minute). A request is taken on a rising
//   edge with in_valid high and in_stall low.
// - Result channel: out_valid / out_stall carry one result per request: the
//   menu state after the button, the shown time, the target indicator and the
//   clock-set / alarm-write strobes.
// - Throughput: one request per cycle while in_stall is low.
// - The state update is a single pass of logic from the request ports into
//   the state and result registers, so each result is registered.
// - When the receiver stalls, a second result is held in a skid register and
//   in_stall rises only once both the result and skid registers are full.
// - Reset (arst_n low) returns the menu to idle, clears the working time and
//   both alarms (disabled, 00:00) and empties the result buffer.
module clock_alarm_set_menu_fsm_top
	import casm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         operation,
	input  logic               alarms_silent,
	input  logic [HourW-1:0]   clock_hour,
	input  logic [MinuteW-1:0] clock_minute,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         menu_state,
	output logic [HourW-1:0]   shown_hour,
	output logic [MinuteW-1:0] shown_minute,
	output logic               show_disabled,
	output logic [1:0]         target_indicator,
	output logic               set_clock,
	output logic [1:0]         alarm_written,
	output logic               written_enabled
);

	logic    take;
	logic    full;
	result_t core_res;
	result_t out_res;

	assign in_stall = full;
	assign take     = in_valid && !full;

	// Menu state machine
	casm_menu_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (take),
		.operation     (operation),
		.alarms_silent (alarms_silent),
		.clock_hour    (clock_hour),
		.clock_minute  (clock_minute),
		.result        (core_res)
	);

	// Result buffer
	casm_out_buf u_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take),
		.push_data (core_res),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_res)
	);

	// Result fields
	assign menu_state       = out_res.menu_state;
	assign shown_hour       = out_res.shown_hour;
	assign shown_minute     = out_res.shown_minute;
	assign show_disabled    = out_res.show_disabled;
	assign target_indicator = out_res.target_indicator;
	assign set_clock        = out_res.set_clock;
	assign alarm_written    = out_res.alarm_written;
	assign written_enabled  = out_res.written_enabled;

endmodule
